// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ctf_pkg.sv =====
// Package: shared constants, codes and result type for the compacting table
`timescale 1ns / 1ps

package ctf_pkg;

	localparam int DEF_TABLE_DEPTH = 16;
	localparam int DEF_NAME_BYTES  = 8;

	localparam int KEY_W    = 64;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 8;
	localparam int IDX_W    = 4;
	localparam int CMP_W    = 8;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_FILTER = 2'd3;

	localparam logic [1:0] RC_OK        = 2'd0;
	localparam logic [1:0] RC_FULL      = 2'd1;
	localparam logic [1:0] RC_NOT_FOUND = 2'd2;
	localparam logic [1:0] RC_BAD_INDEX = 2'd3;

	typedef struct packed {
		logic [1:0]          code;
		logic [IDX_W-1:0]    idx;
		logic [KEY_W-1:0]    name;
		logic [DATA_W-1:0]   data;
		logic [STATUS_W-1:0] status;
		logic                valid;
		logic                last;
	} result_t;

endpackage

// ===== hw/rtl/ctf_obuf.sv =====
// Output register stage: holds one result while the consumer stalls
`timescale 1ns / 1ps

module ctf_obuf import ctf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_d,
	input  logic    out_stall,
	output logic    can_load,
	output logic    out_valid,
	output result_t res_q
);

	logic valid_q;

	assign can_load  = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

// ===== hw/rtl/compacting_table_with_ternary_filter.sv =====
// Top level: compacting key table with append, find, remove and ternary status filter
// Append and bad-index remove: answered from idle, result loaded into the output register.
// Find: walk until a hit or the end; filter: walk of all entries, held by output stalls.
// Remove: later entries move down one place; one read per cycle unless a scan stalls.
// One item at a time: a transfer is accepted when idle and the output register can load.
// Reset (arst_n low, asynchronous) empties the table and clears sequencer and output valid.
`timescale 1ns / 1ps

module compacting_table_with_ternary_filter import ctf_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int NAME_BYTES  = DEF_NAME_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [KEY_W-1:0]    name_key,
	input  logic [DATA_W-1:0]   entry_data,
	input  logic [STATUS_W-1:0] entry_status,
	input  logic [IDX_W-1:0]    entry_index,
	input  logic [STATUS_W-1:0] pattern_ones,
	input  logic [STATUS_W-1:0] pattern_wild,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          result_code,
	output logic [IDX_W-1:0]    found_index,
	output logic [KEY_W-1:0]    out_name_key,
	output logic [DATA_W-1:0]   out_data,
	output logic [STATUS_W-1:0] out_status,
	output logic                entry_valid,
	output logic                last_result
);

	// Stored name width: only the low NAME_BYTES bytes of a key take part
	localparam int NAME_W = 8 * NAME_BYTES;
	localparam int ENT_W  = NAME_W + DATA_W + STATUS_W;
	// Address into the store and a count that can also hold the depth itself
	localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW     = $clog2(TABLE_DEPTH + 1);

	// Sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;	// find or filter walk
	localparam logic [1:0] ST_SHIFT = 2'd2;	// remove: copy entries down one place

	logic [1:0]          state_q;
	logic [CW-1:0]       cnt_q;		// entries in use
	logic [CW-1:0]       ptr_q;		// next address to read
	logic                vld_s1;		// a read is in flight to the check stage
	logic [AW-1:0]       idx_s1;		// address of that read
	logic [ENT_W-1:0]    mem_rd_s1;	// registered read data

	// Operation captured at transfer time
	logic [1:0]          op_q;
	logic [NAME_W-1:0]   key_q;
	logic [STATUS_W-1:0] ones_q;
	logic [STATUS_W-1:0] wild_q;

	// Entry store. Entries at and beyond cnt_q are never read, so it needs no clearing.
	logic [ENT_W-1:0]    mem [TABLE_DEPTH];

	logic                accept;
	logic                can_load;
	logic                emit;
	logic                load;
	logic                stall_s;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [ENT_W-1:0]    wr_data;
	logic                scan_done;
	logic                key_hit;
	logic                stat_hit;
	logic                append_full;
	logic                remove_bad;
	logic [NAME_W-1:0]   rd_name;
	logic [DATA_W-1:0]   rd_data;
	logic [STATUS_W-1:0] rd_status;
	result_t             res_d;
	result_t             res_q;

	assign in_stall = (state_q != ST_IDLE) || !can_load;
	assign accept   = in_valid && !in_stall;

	assign rd_name   = mem_rd_s1[ENT_W-1 -: NAME_W];
	assign rd_data   = mem_rd_s1[STATUS_W +: DATA_W];
	assign rd_status = mem_rd_s1[STATUS_W-1:0];

	// Ternary compare: wild bits match anything, the rest must equal the ones pattern
	assign key_hit  = (rd_name == key_q);
	assign stat_hit = (((rd_status ^ ones_q) & ~wild_q) == '0);

	// Walk finished: every address issued and nothing left in the check stage
	assign scan_done = (ptr_q == cnt_q) && !vld_s1;

	assign append_full = (cnt_q >= CW'(TABLE_DEPTH));
	assign remove_bad  = ({{(CMP_W - IDX_W){1'b0}}, entry_index} >= CMP_W'(cnt_q));
	assign rd_addr     = ptr_q[AW-1:0];

	always_comb begin
		emit    = 1'b0;
		res_d   = '0;
		res_d.last = 1'b1;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		stall_s = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (opcode == OP_APPEND) begin
						emit = 1'b1;
						if (append_full) begin
							res_d.code = RC_FULL;
						end else begin
							res_d.code = RC_OK;
							wr_en      = 1'b1;
							wr_addr    = cnt_q[AW-1:0];
							wr_data    = {name_key[NAME_W-1:0], entry_data, entry_status};
						end
					end else if (opcode == OP_REMOVE && remove_bad) begin
						emit       = 1'b1;
						res_d.code = RC_BAD_INDEX;
					end
				end
			end
			ST_SCAN: begin
				if (vld_s1 && op_q == OP_FIND && key_hit) begin
					emit       = 1'b1;
					res_d.code = RC_OK;
					res_d.idx  = IDX_W'(idx_s1);
				end else if (vld_s1 && op_q == OP_FILTER && stat_hit) begin
					emit         = 1'b1;
					res_d.code   = RC_OK;
					res_d.name   = KEY_W'(rd_name);
					res_d.data   = rd_data;
					res_d.status = rd_status;
					res_d.valid  = 1'b1;
					res_d.last   = 1'b0;
				end else if (scan_done) begin
					emit       = 1'b1;
					res_d.code = (op_q == OP_FIND) ? RC_NOT_FOUND : RC_OK;
				end
				stall_s = emit && !can_load;
				// no new read once find has its hit
				rd_en = !stall_s && (ptr_q < cnt_q) &&
					!(vld_s1 && op_q == OP_FIND && key_hit);
			end
			ST_SHIFT: begin
				wr_en   = vld_s1;
				wr_addr = idx_s1 - AW'(1);
				wr_data = mem_rd_s1;
				rd_en   = (ptr_q < cnt_q);
				if (scan_done) begin
					emit       = 1'b1;
					res_d.code = RC_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign load = emit && can_load;

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						priority if (opcode == OP_APPEND) begin
							if (!append_full) begin
								cnt_q <= cnt_q + CW'(1);
							end
						end else if (opcode == OP_REMOVE) begin
							if (!remove_bad) begin
								state_q <= ST_SHIFT;
								ptr_q   <= CW'(entry_index) + CW'(1);
							end
						end else begin
							state_q <= ST_SCAN;
							ptr_q   <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (!stall_s) begin
						vld_s1 <= rd_en;
						if (rd_en) begin
							ptr_q <= ptr_q + CW'(1);
						end
						if (emit && (res_d.last)) begin
							state_q <= ST_IDLE;
							vld_s1  <= 1'b0;
						end
					end
				end
				ST_SHIFT: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (scan_done && can_load) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Captured operands and read address tag
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			key_q  <= name_key[NAME_W-1:0];
			ones_q <= pattern_ones;
			wild_q <= pattern_wild;
		end
		if (rd_en) begin
			idx_s1 <= rd_addr;
		end
	end

	// Store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_addr];
		end
	end

	ctf_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res_d     (res_d),
		.out_stall (out_stall),
		.can_load  (can_load),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign result_code  = res_q.code;
	assign found_index  = res_q.idx;
	assign out_name_key = res_q.name;
	assign out_data     = res_q.data;
	assign out_status   = res_q.status;
	assign entry_valid  = res_q.valid;
	assign last_result  = res_q.last;

endmodule

// ===== hw/rtl/ctf_checker.sv =====
// Port-level checker for the compacting table, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctf_checker import ctf_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic [1:0]          opcode,
	input logic                out_valid,
	input logic                out_stall,
	input logic [1:0]          result_code,
	input logic [IDX_W-1:0]    found_index,
	input logic [KEY_W-1:0]    out_name_key,
	input logic [DATA_W-1:0]   out_data,
	input logic [STATUS_W-1:0] out_status,
	input logic                entry_valid,
	input logic                last_result
);

	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_name_key) && $stable(out_data) && $stable(out_status) && $stable(result_code) && $stable(last_result), "stalled result changed")
	`CHK_NEXT(a_scan_busy, clk, arst_n, in_valid && !in_stall && (opcode == OP_FIND || opcode == OP_FILTER), in_stall, "table took a transfer during a scan")
	`CHK_SAME(a_last_xor_entry, clk, arst_n, out_valid, entry_valid != last_result, "filtered entry and closing flag disagree")
	`CHK_SAME(a_entry_code, clk, arst_n, out_valid && entry_valid, result_code == RC_OK && found_index == '0, "filtered entry with bad code or index")

endmodule

bind compacting_table_with_ternary_filter ctf_checker u_ctf_checker (.*);
